// ===== rtl/core/wpf_pkg.sv =====
// Shared types and constants for the waypoint path follower.
// No dependencies; used by every module in rtl/core.
package wpf_pkg;

  localparam int MAX_POINTS = 16;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int COORD_W    = 24;
  localparam int TIME_W     = 24;
  localparam int DELTA_W    = 16;
  localparam int ELAPSED_W  = 25;
  localparam int FRAC_W     = 16;
  localparam int PADDR_W    = 3;

  localparam logic [PADDR_W-1:0] ADDR_WAIT_TIME    = 3'd0;
  localparam logic [PADDR_W-1:0] ADDR_RETURN_ROUTE = 3'd4;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic             take;      // latch the input transaction
    logic             decide;    // add, or tick that needs no interpolation
    logic             rd_from;   // table read address selects from_index
    logic             cap_start; // capture start point from read data
    logic             resolve;   // compare elapsed with segment time
    logic             mul;       // multiply one axis difference by fraction
    logic             acc;       // add the product to the start coordinate
    logic [1:0]       axis;
    logic             step;      // advance elapsed after interpolation
    logic             emit;      // load the output register
  } cmd_t;

  typedef struct packed {
    logic need_move;
    logic seg_less;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/core/waypoint_path_follower.sv =====
// Waypoint path follower top level: stream ports, APB register file.
// Depends on wpf_pkg, wpf_ctrl, wpf_datapath.
// One transaction is handled at a time. An add or a tick that only waits
// passes through the decide and done states; a tick that reaches the segment
// end also reads the start and end points and compares; an interpolating tick
// further runs the 16-step bit-serial divider for the fraction and the one
// multiplier shared over the three axes, then advances elapsed time.
// The next transaction is accepted once the result is loaded into the output
// register, so a stalled receiver holds the input off. The point table reads
// as garbage for entries never written; the route never visits them.
module waypoint_path_follower (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // point_x, point_y, point_z, segment_time, delta_time
  input  logic [111:0]                  s_tdata,
  // op
  input  logic                          s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // pos_x, pos_y, pos_z, moving, dropped, zero fill
  output logic [79:0]                   m_tdata,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wpf_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  wpf_pkg::cmd_t    cmd;
  wpf_pkg::status_t status;
  logic [wpf_pkg::TIME_W-1:0] wait_time;
  logic                       return_route;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wait_time    <= '0;
      return_route <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (paddr)
        wpf_pkg::ADDR_WAIT_TIME:    wait_time    <= pwdata[wpf_pkg::TIME_W-1:0];
        wpf_pkg::ADDR_RETURN_ROUTE: return_route <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      wpf_pkg::ADDR_WAIT_TIME:    prdata = {8'd0, wait_time};
      wpf_pkg::ADDR_RETURN_ROUTE: prdata = {31'd0, return_route};
      default:                    prdata = '0;
    endcase
  end

  wpf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  wpf_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .wait_time    (wait_time),
    .return_route (return_route),
    .in_data      (s_tdata),
    .in_op        (s_tuser),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_data     (m_tdata)
  );

endmodule

// ===== rtl/core/wpf_div.sv =====
// Restoring divider for the Q0.16 move fraction, one quotient bit per cycle.
// Depends on wpf_pkg. Requires num < den.
module wpf_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [wpf_pkg::TIME_W-1:0]   num,
  input  logic [wpf_pkg::TIME_W-1:0]   den,
  output logic [wpf_pkg::FRAC_W-1:0]   quot,
  output logic                         done
);

  logic [wpf_pkg::TIME_W-1:0]  rem;
  logic [wpf_pkg::TIME_W-1:0]  den_r;
  logic [wpf_pkg::FRAC_W-1:0]  q;
  logic [4:0]                  cnt;
  logic                        busy;
  logic [wpf_pkg::TIME_W:0]    r2;
  logic                        ge;

  assign r2   = {rem, 1'b0};
  assign ge   = r2 >= {1'b0, den_r};
  assign quot = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'(wpf_pkg::FRAC_W);
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= num;
      den_r <= den;
      q     <= '0;
    end else if (busy) begin
      if (ge) begin
        rem <= wpf_pkg::TIME_W'(r2 - {1'b0, den_r});
      end else begin
        rem <= r2[wpf_pkg::TIME_W-1:0];
      end
      q <= {q[wpf_pkg::FRAC_W-2:0], ge};
    end
  end

endmodule

// ===== rtl/core/wpf_datapath.sv =====
// Datapath: point table, route state, interpolation and output register.
// Depends on wpf_pkg and wpf_div; driven by wpf_ctrl commands.
module wpf_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  wpf_pkg::cmd_t                 cmd,
  output wpf_pkg::status_t              status,
  input  logic [wpf_pkg::TIME_W-1:0]    wait_time,
  input  logic                          return_route,
  input  logic [111:0]                  in_data,
  input  logic                          in_op,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [79:0]                   out_data
);

  localparam int CW = wpf_pkg::COORD_W;
  localparam int IW = wpf_pkg::IDX_W;
  localparam int NW = wpf_pkg::CNT_W;
  localparam int EW = wpf_pkg::ELAPSED_W;
  localparam int TW = wpf_pkg::TIME_W;
  localparam int PW = 3 * CW + TW;

  logic [PW-1:0]               mem [wpf_pkg::MAX_POINTS];
  logic [PW-1:0]               rdata;
  logic [IW-1:0]               rd_addr;

  logic                        op;
  logic [PW-1:0]               item_pt;
  logic [wpf_pkg::DELTA_W-1:0] delta;
  logic [NW-1:0]               count;
  logic                        moving;
  logic                        rev;
  logic [IW-1:0]               from_idx;
  logic [IW-1:0]               to_idx;
  logic [EW-1:0]               elapsed;
  logic [CW-1:0]               pos [3];
  logic                        dropped;
  logic [PW-1:0]               start_pt;

  logic [EW:0]                 sum;
  logic [EW-1:0]               elapsed_sat;
  logic [TW-1:0]               seg;
  logic [NW-1:0]               fwd;
  logic [wpf_pkg::FRAC_W-1:0]  frac;
  logic                        div_done;
  logic [CW-1:0]               s_ax;
  logic [CW-1:0]               e_ax;
  logic signed [CW:0]          diff;
  logic signed [CW+wpf_pkg::FRAC_W+1:0] prod;

  assign sum         = {1'b0, elapsed} + (EW+1)'(delta);
  assign elapsed_sat = sum[EW] ? {EW{1'b1}} : sum[EW-1:0];
  assign seg         = rev ? start_pt[TW-1:0] : rdata[TW-1:0];
  assign fwd         = NW'(from_idx) + NW'(1);
  assign rd_addr     = cmd.rd_from ? from_idx : to_idx;

  // point layout from low bits: time, z, y, x
  assign s_ax = start_pt[TW + (2 - cmd.axis) * CW +: CW];
  assign e_ax = rdata[TW + (2 - cmd.axis) * CW +: CW];
  assign diff = $signed({e_ax[CW-1], e_ax}) - $signed({s_ax[CW-1], s_ax});

  assign status.need_move = (op == wpf_pkg::OP_TICK) && (count >= NW'(2)) && moving;
  assign status.seg_less  = {1'b0, elapsed} < (EW+1)'(seg);
  assign status.div_done  = div_done;
  assign status.out_free  = !out_valid || out_ready;

  wpf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.resolve && status.seg_less),
    .num   (elapsed[TW-1:0]),
    .den   (seg),
    .quot  (frac),
    .done  (div_done)
  );

  always_ff @(posedge clk) begin
    rdata <= mem[rd_addr];
    if (cmd.decide && op == wpf_pkg::OP_ADD && count < NW'(wpf_pkg::MAX_POINTS)) begin
      mem[count[IW-1:0]] <= item_pt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op      <= in_op;
      item_pt <= {in_data[23:0], in_data[47:24], in_data[71:48], in_data[95:72]};
      delta   <= in_data[111:96];
    end
    if (cmd.cap_start) begin
      start_pt <= rdata;
    end
    if (cmd.mul) begin
      prod <= diff * $signed({1'b0, frac});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      moving    <= 1'b0;
      rev       <= 1'b0;
      from_idx  <= '0;
      to_idx    <= '0;
      elapsed   <= '0;
      pos[0]    <= '0;
      pos[1]    <= '0;
      pos[2]    <= '0;
      dropped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.decide) begin
        dropped <= (op == wpf_pkg::OP_ADD) && (count >= NW'(wpf_pkg::MAX_POINTS));
        if (op == wpf_pkg::OP_ADD) begin
          if (count < NW'(wpf_pkg::MAX_POINTS)) begin
            count <= count + NW'(1);
            if (count == '0) begin
              pos[0] <= item_pt[TW + 2*CW +: CW];
              pos[1] <= item_pt[TW + CW +: CW];
              pos[2] <= item_pt[TW +: CW];
            end
          end
        end else if (count >= NW'(2) && !moving) begin
          if (elapsed < EW'(wait_time)) begin
            elapsed <= elapsed_sat;
          end else begin
            elapsed <= elapsed - EW'(wait_time);
            moving  <= 1'b1;
            if (!rev) begin
              if (fwd >= count) begin
                if (return_route && from_idx != '0) begin
                  to_idx <= from_idx - IW'(1);
                  rev    <= 1'b1;
                end else begin
                  to_idx <= '0;
                end
              end else begin
                to_idx <= fwd[IW-1:0];
              end
            end else if (from_idx == '0) begin
              to_idx <= IW'(1);
              rev    <= 1'b0;
            end else begin
              to_idx <= from_idx - IW'(1);
            end
          end
        end
      end
      if (cmd.resolve && !status.seg_less) begin
        pos[0]   <= rdata[TW + 2*CW +: CW];
        pos[1]   <= rdata[TW + CW +: CW];
        pos[2]   <= rdata[TW +: CW];
        from_idx <= to_idx;
        elapsed  <= elapsed - EW'(seg);
        moving   <= 1'b0;
      end
      if (cmd.acc) begin
        pos[cmd.axis] <= s_ax + prod[CW+wpf_pkg::FRAC_W-1:wpf_pkg::FRAC_W];
      end
      if (cmd.step) begin
        elapsed <= elapsed_sat;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
        out_data  <= {6'd0, dropped, moving, pos[2], pos[1], pos[0]};
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/wpf_ctrl.sv =====
// Controller state machine sequencing one transaction through the datapath.
// Depends on wpf_pkg.
module wpf_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  wpf_pkg::status_t status,
  output wpf_pkg::cmd_t    cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECIDE = 4'd1;
  localparam logic [3:0] S_RDS    = 4'd2;
  localparam logic [3:0] S_RDE    = 4'd3;
  localparam logic [3:0] S_CMP    = 4'd4;
  localparam logic [3:0] S_DIV    = 4'd5;
  localparam logic [3:0] S_MUL    = 4'd6;
  localparam logic [3:0] S_ACC    = 4'd7;
  localparam logic [3:0] S_STEP   = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;
  logic [1:0] axis;
  logic [1:0] axis_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    axis_next  = axis;
    cmd        = '0;
    cmd.axis   = axis;
    case (state)
      S_IDLE: begin
        cmd.take = in_valid;
        if (in_valid) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = status.need_move ? S_RDS : S_DONE;
      end
      S_RDS: begin
        cmd.rd_from = 1'b1;
        state_next  = S_RDE;
      end
      S_RDE: begin
        cmd.cap_start = 1'b1;
        state_next    = S_CMP;
      end
      S_CMP: begin
        cmd.resolve = 1'b1;
        axis_next   = 2'd0;
        state_next  = status.seg_less ? S_DIV : S_DONE;
      end
      S_DIV: begin
        if (status.div_done) state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (axis == 2'd2) begin
          state_next = S_STEP;
        end else begin
          axis_next  = axis + 2'd1;
          state_next = S_MUL;
        end
      end
      S_STEP: begin
        cmd.step   = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      axis  <= '0;
    end else begin
      state <= state_next;
      axis  <= axis_next;
    end
  end

endmodule

// ===== test/testbench.sv =====
// Self-checking bench for waypoint_path_follower: directed and random add/tick traffic.
// Depends on wpf_pkg and the RTL top; positions are predicted in-bench and
// compared field by field with every result transaction.
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
    logic [23:0]        t;
  } wpt_t;

  typedef struct {
    logic [23:0] px, py, pz;
    logic        moving;
    logic        dropped;
  } pos_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [111:0] s_tdata = '0;
  logic         s_tuser = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [79:0]  m_tdata;
  logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [wpf_pkg::PADDR_W-1:0] paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  waypoint_path_follower u_top (.*);

  always #6 clk = ~clk;

  // predictor state
  wpt_t        route [wpf_pkg::MAX_POINTS];
  int unsigned n_pts, from_i, to_i, elapsed_ms, pause_ms;
  bit          in_move, backwards, ping_pong;
  logic signed [23:0] cur [3];
  pos_t        pending_pos [$];

  int  errors = 0;
  bit  rx_quiet = 0;     // no stalls from the receiver
  int  rx_hold  = 0;     // forced long stall, cycles
  bit  tx_quiet = 0;
  int  idle_cycles = 0;

  function automatic logic signed [23:0] blend(logic signed [23:0] a,
      logic signed [23:0] b, int unsigned f);
    longint prod;
    prod = (longint'(b) - longint'(a)) * longint'(f);
    return 24'(longint'(a) + (prod >>> 16));
  endfunction

  function automatic void choose_target();
    if (!backwards) begin
      to_i = from_i + 1;
      if (to_i >= n_pts) begin
        if (ping_pong && from_i > 0) begin
          to_i = from_i - 1;
          backwards = 1;
        end else begin
          to_i = 0;
        end
      end
    end else if (from_i == 0) begin
      to_i = 1;
      backwards = 0;
    end else begin
      to_i = from_i - 1;
    end
  endfunction

  function automatic int unsigned sat_sum(int unsigned e, int unsigned d);
    return (e + d > 32'h1FF_FFFF) ? 32'h1FF_FFFF : e + d;
  endfunction

  function automatic void advance_time(int unsigned dt);
    wpt_t s, e;
    int unsigned seg, f;
    if (n_pts < 2) return;
    if (!in_move) begin
      if (elapsed_ms < pause_ms) elapsed_ms = sat_sum(elapsed_ms, dt);
      else begin
        elapsed_ms -= pause_ms;
        choose_target();
        in_move = 1;
      end
    end else begin
      s = route[from_i];
      e = route[to_i];
      seg = backwards ? s.t : e.t;
      if (elapsed_ms < seg) begin
        f = int'((longint'(elapsed_ms) << 16) / seg);
        cur[0] = blend(s.x, e.x, f);
        cur[1] = blend(s.y, e.y, f);
        cur[2] = blend(s.z, e.z, f);
        elapsed_ms = sat_sum(elapsed_ms, dt);
      end else begin
        cur[0] = e.x; cur[1] = e.y; cur[2] = e.z;
        from_i = to_i;
        elapsed_ms -= seg;
        in_move = 0;
      end
    end
  endfunction

  function automatic void predict_position(logic op, wpt_t p, logic [15:0] dt);
    pos_t r;
    r.dropped = 1'b0;
    if (op == wpf_pkg::OP_ADD) begin
      if (n_pts >= wpf_pkg::MAX_POINTS) r.dropped = 1'b1;
      else begin
        route[n_pts] = p;
        n_pts++;
        if (n_pts == 1) begin
          cur[0] = p.x; cur[1] = p.y; cur[2] = p.z;
        end
      end
    end else begin
      advance_time(dt);
    end
    r.px = cur[0]; r.py = cur[1]; r.pz = cur[2];
    r.moving = in_move;
    pending_pos.insert(pending_pos.size(), r);
  endfunction

  // one transaction on the input stream
  task automatic send_item(logic op, wpt_t p, logic [15:0] dt);
    @(negedge clk);
    if (!tx_quiet && $urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 14)) @(negedge clk);
    s_tuser  <= op;
    s_tdata  <= {dt, p.t, p.z, p.y, p.x};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_position(op, p, dt);
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  task automatic add_point(int x, int y, int z, int t);
    wpt_t p;
    p.x = 24'(x); p.y = 24'(y); p.z = 24'(z); p.t = 24'(t);
    send_item(wpf_pkg::OP_ADD, p, 16'($urandom));
  endtask

  task automatic tick(int dt);
    wpt_t p;
    p = {$urandom, $urandom, $urandom};
    send_item(wpf_pkg::OP_TICK, p, 16'(dt));
  endtask

  task automatic drain();
    while (pending_pos.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(logic [wpf_pkg::PADDR_W-1:0] addr, int unsigned val);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == wpf_pkg::ADDR_WAIT_TIME) pause_ms = val[23:0];
    else if (addr == wpf_pkg::ADDR_RETURN_ROUTE) ping_pong = val[0];
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(negedge clk);
  endtask

  // fresh route needs a reset-like state; route table only grows, so phases
  // reuse the filled table and vary timing and config instead
  task automatic test_directed();
    write_reg(wpf_pkg::ADDR_WAIT_TIME, 0);
    write_reg(wpf_pkg::ADDR_RETURN_ROUTE, 0);
    tick(5);                                   // no points: position held
    add_point(24'sh7FFFFF, 24'sh800000, 0, 10);
    tick(65535);                               // one point: still held
    add_point(24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 16'hFFFF);
    add_point(100, -100, 256, 1);
    add_point(-5, 7, -9, 24'hFFFFFF);
    add_point(0, 0, 0, 0);                     // zero segment time
    repeat (12) tick($urandom_range(0, 70000));
    tick(0);
    tick(65535);
  endtask

  task automatic test_fill_table();
    while (n_pts < wpf_pkg::MAX_POINTS)
      add_point($urandom, $urandom, $urandom, $urandom_range(1, 3000));
    repeat (3) add_point($urandom, $urandom, $urandom, $urandom);  // dropped
  endtask

  task automatic run_ticks(int count, int unsigned max_dt);
    repeat (count) begin
      if ($urandom_range(0, 19) == 0)
        add_point($urandom, $urandom, $urandom, $urandom);
      else
        tick($urandom_range(0, max_dt));
    end
  endtask

  task automatic test_forward_loop();
    drain();
    write_reg(wpf_pkg::ADDR_WAIT_TIME, 300);
    write_reg(wpf_pkg::ADDR_RETURN_ROUTE, 0);
    run_ticks(150, 700);
  endtask

  task automatic test_ping_pong();
    drain();
    write_reg(wpf_pkg::ADDR_WAIT_TIME, 0);
    write_reg(wpf_pkg::ADDR_RETURN_ROUTE, 1);
    run_ticks(150, 1500);
  endtask

  task automatic test_backpressure();
    rx_hold = 300;
    run_ticks(20, 500);
    drain();                                   // sender pauses for all results
    run_ticks(20, 500);
  endtask

  task automatic test_long_wait();
    drain();
    write_reg(wpf_pkg::ADDR_WAIT_TIME, 24'hFFFFFF);
    run_ticks(40, 65535);
    drain();
    write_reg(wpf_pkg::ADDR_WAIT_TIME, 50);
    write_reg(wpf_pkg::ADDR_RETURN_ROUTE, 1);
    run_ticks(100, 400);
  endtask

  task automatic test_no_idle();
    tx_quiet = 1;
    rx_quiet = 1;
    run_ticks(100, 2000);
  endtask

  // receiver: random stalls, plus a forced long hold-off
  initial begin
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        m_tready <= 1'b0;
        repeat (rx_hold) @(negedge clk);
        rx_hold = 0;
      end else if (!rx_quiet && $urandom_range(0, 9) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 14) - 1) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    pos_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_pos.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transaction %h", m_tdata);
      end else begin
        e = pending_pos.pop_front();
        if (m_tdata[23:0] !== e.px || m_tdata[47:24] !== e.py ||
            m_tdata[71:48] !== e.pz || m_tdata[72] !== e.moving ||
            m_tdata[73] !== e.dropped) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp x=%h y=%h z=%h mv=%b dr=%b, got x=%h y=%h z=%h mv=%b dr=%b",
                     e.px, e.py, e.pz, e.moving, e.dropped, m_tdata[23:0],
                     m_tdata[47:24], m_tdata[71:48], m_tdata[72], m_tdata[73]);
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    n_pts = 0; from_i = 0; to_i = 0; elapsed_ms = 0; pause_ms = 0;
    in_move = 0; backwards = 0; ping_pong = 0;
    cur[0] = 0; cur[1] = 0; cur[2] = 0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_fill_table();
    test_forward_loop();
    test_ping_pong();
    test_backpressure();
    test_long_wait();
    test_no_idle();
    drain();
    if (errors == 0 && pending_pos.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
